// ===== design/trhp_pkg.sv =====
package trhp_pkg;

	localparam int CAPTURE_DEPTH = 4096;
	localparam int CAP_AW = $clog2(CAPTURE_DEPTH);
	localparam int CAP_LW = $clog2(CAPTURE_DEPTH + 1);
	localparam int JOB_Q_DEPTH = 2;
	localparam int JOB_QAW = $clog2(JOB_Q_DEPTH);
	localparam int OUT_W = 152;

	// event bit positions
	localparam int EV_RECORD = 0;
	localparam int EV_HELLO = 1;
	localparam int EV_CERT = 2;
	localparam int EV_KEYX = 3;
	localparam int EV_CREQ = 4;
	localparam int EV_DONE = 5;
	localparam int EV_ALERT = 6;
	localparam int EV_CCS = 7;
	localparam int EV_ERROR = 8;

	// record content types
	localparam logic [7:0] REC_CCS = 8'd20;
	localparam logic [7:0] REC_ALERT = 8'd21;
	localparam logic [7:0] REC_HS = 8'd22;
	localparam logic [7:0] REC_APP = 8'd23;

	// handshake message types
	localparam logic [7:0] HS_HELLO = 8'd2;
	localparam logic [7:0] HS_CERT = 8'd11;
	localparam logic [7:0] HS_KEYX = 8'd12;
	localparam logic [7:0] HS_CREQ = 8'd13;
	localparam logic [7:0] HS_DONE = 8'd14;

	localparam logic [7:0] ALERT_FATAL = 8'd2;
	localparam logic [7:0] CURVE_NAMED = 8'd3;
	localparam int REC_HDR_LAST = 4;
	localparam int HS_HDR_LAST = 3;
	localparam int HELLO_MIN = 38;
	localparam int SID_OFS = 34;
	localparam int SID_MAX = 32;
	localparam int CERT_HDR = 3;
	localparam int KEYX_MIN = 4;
	localparam int CNT_MAX = 2047;

	typedef struct packed {
		logic restart;
		logic err_only;
		logic pend_clear;
		logic oversize;
		logic trunc_clear;
		logic trunc_set;
		logic msg;
		logic [7:0] msg_kind;
		logic [CAP_LW-1:0] msg_len;
		logic rec_end;
		logic [7:0] rec_kind;
		logic rec_ge2;
		logic [7:0] alert0;
		logic [7:0] alert1;
	} job_t;

	typedef struct packed {
		logic idle;
		logic sticky;
		logic pend_err;
	} bstat_t;

	typedef enum logic [4:0] {
		B_IDLE,
		B_START,
		B_DISP,
		B_RD,
		B_RDW,
		B_H_VER,
		B_H_SID,
		B_H_CIPH,
		B_H_COMP,
		B_C_CHAIN,
		B_C_LOOP,
		B_C_LEN,
		B_C_END,
		B_K_0,
		B_K_NG,
		B_AFTER,
		B_FIN,
		B_EMIT
	} bstate_t;

endpackage

// ===== design/trhp_ram.sv =====
module trhp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/trhp_queue.sv =====
module trhp_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input trhp_pkg::job_t push_job,
	input logic pop,
	output trhp_pkg::job_t head,
	output logic empty
);
	import trhp_pkg::*;

	job_t mem_q [JOB_Q_DEPTH];
	logic [JOB_QAW-1:0] wp_q, rp_q;
	logic [JOB_QAW:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == JOB_QAW'(JOB_Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == JOB_QAW'(JOB_Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (JOB_QAW + 1)'(push) - (JOB_QAW + 1)'(pop);
		end
	end

endmodule

// ===== design/trhp_front.sv =====
module trhp_front (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,
	input logic [0:0] s_tuser,
	input logic [15:0] record_limit,
	input trhp_pkg::bstat_t stat,
	input logic q_empty,
	output logic push,
	output trhp_pkg::job_t job,
	output logic cap_we,
	output logic [trhp_pkg::CAP_AW-1:0] cap_waddr,
	output logic [7:0] cap_wdata
);
	import trhp_pkg::*;

	logic [2:0] rhc_q, n_rhc;
	logic [7:0] rkind_q, n_rkind;
	logic [15:0] rlen_q, n_rlen;
	logic [15:0] rrecv_q, n_rrecv;
	logic [7:0] al0_q, n_al0, al1_q, n_al1;
	logic [2:0] hhc_q, n_hhc;
	logic [7:0] hkind_q, n_hkind;
	logic [23:0] hlen_q, n_hlen;
	logic [23:0] hrecv_q, n_hrecv;
	logic acc;
	logic [7:0] b;

	assign s_tready = q_empty & stat.idle;
	assign acc = s_tvalid & s_tready;
	assign b = s_tdata;
	assign cap_wdata = s_tdata;
	assign cap_waddr = hrecv_q[CAP_AW-1:0];

	always_comb begin
		n_rhc = rhc_q;
		n_rkind = rkind_q;
		n_rlen = rlen_q;
		n_rrecv = rrecv_q;
		n_al0 = al0_q;
		n_al1 = al1_q;
		n_hhc = hhc_q;
		n_hkind = hkind_q;
		n_hlen = hlen_q;
		n_hrecv = hrecv_q;
		job = '0;
		cap_we = 1'b0;
		if (acc) begin
			if (s_tuser[0]) begin
				n_rhc = '0;
				n_rkind = '0;
				n_rlen = '0;
				n_rrecv = '0;
				n_al0 = '0;
				n_al1 = '0;
				n_hhc = '0;
				n_hkind = '0;
				n_hlen = '0;
				n_hrecv = '0;
				job.restart = 1'b1;
			end else if (stat.sticky) begin
				job.err_only = 1'b1;
			end else if (rhc_q <= 3'(REC_HDR_LAST)) begin
				n_rhc = rhc_q + 3'd1;
				case (rhc_q)
					3'd0: n_rkind = b;
					3'd3: n_rlen = {b, 8'h00};
					3'd4: n_rlen = {rlen_q[15:8], b};
					default: ;
				endcase
				if (rhc_q == 3'(REC_HDR_LAST)) begin
					n_rrecv = '0;
					job.pend_clear = 1'b1;
					if (n_rlen > record_limit) begin
						job.oversize = 1'b1;
					end else if (n_rlen == '0) begin
						// empty record closes at its header
						job.rec_end = 1'b1;
						job.rec_kind = rkind_q;
						job.rec_ge2 = 1'b0;
						job.alert0 = al0_q;
						job.alert1 = al1_q;
						n_rhc = '0;
						n_rlen = '0;
					end
				end
			end else begin
				if (rkind_q == REC_HS && !stat.pend_err) begin
					if (hhc_q <= 3'(HS_HDR_LAST)) begin
						if (hhc_q == '0) begin
							n_hkind = b;
							n_hlen = '0;
						end else begin
							n_hlen = {hlen_q[15:0], b};
						end
						n_hhc = hhc_q + 3'd1;
						if (hhc_q == 3'(HS_HDR_LAST)) begin
							n_hrecv = '0;
							job.trunc_clear = 1'b1;
							if (n_hlen == '0) begin
								job.msg = 1'b1;
								job.msg_kind = hkind_q;
								job.msg_len = '0;
								n_hhc = '0;
							end
						end
					end else begin
						if (hrecv_q < 24'(CAPTURE_DEPTH)) begin
							cap_we = 1'b1;
						end else begin
							job.trunc_set = 1'b1;
						end
						n_hrecv = hrecv_q + 24'd1;
						if (n_hrecv == hlen_q) begin
							job.msg = 1'b1;
							job.msg_kind = hkind_q;
							job.msg_len = (hlen_q < 24'(CAPTURE_DEPTH)) ?
								hlen_q[CAP_LW-1:0] : CAP_LW'(CAPTURE_DEPTH);
							n_hhc = '0;
							n_hkind = '0;
							n_hlen = '0;
							n_hrecv = '0;
						end
					end
				end else if (rkind_q == REC_ALERT && rrecv_q < 16'd2) begin
					if (rrecv_q[0]) begin
						n_al1 = b;
					end else begin
						n_al0 = b;
					end
				end
				n_rrecv = rrecv_q + 16'd1;
				if (n_rrecv >= rlen_q) begin
					job.rec_end = 1'b1;
					job.rec_kind = rkind_q;
					job.rec_ge2 = (rlen_q >= 16'd2);
					job.alert0 = n_al0;
					job.alert1 = n_al1;
					n_rhc = '0;
					n_rrecv = '0;
					n_rlen = '0;
				end
			end
		end
	end

	assign push = acc & (job.restart | job.err_only | job.pend_clear | job.trunc_clear |
		job.trunc_set | job.msg | job.rec_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rhc_q <= '0;
			rkind_q <= '0;
			rlen_q <= '0;
			rrecv_q <= '0;
			al0_q <= '0;
			al1_q <= '0;
			hhc_q <= '0;
			hkind_q <= '0;
			hlen_q <= '0;
			hrecv_q <= '0;
		end else begin
			rhc_q <= n_rhc;
			rkind_q <= n_rkind;
			rlen_q <= n_rlen;
			rrecv_q <= n_rrecv;
			al0_q <= n_al0;
			al1_q <= n_al1;
			hhc_q <= n_hhc;
			hkind_q <= n_hkind;
			hlen_q <= n_hlen;
			hrecv_q <= n_hrecv;
		end
	end

endmodule

// ===== design/trhp_back.sv =====
module trhp_back (
	input logic clk,
	input logic arst_n,
	input trhp_pkg::job_t head,
	input logic q_empty,
	output logic pop,
	output trhp_pkg::bstat_t stat,
	output logic [trhp_pkg::CAP_AW-1:0] cap_raddr,
	input logic [7:0] cap_rdata,
	output logic m_tvalid,
	input logic m_tready,
	output logic [trhp_pkg::OUT_W-1:0] m_tdata
);
	import trhp_pkg::*;

	bstate_t state_q, state_n, ret_q;
	job_t job_q;
	logic [8:0] pend_q, ev_q, fin_ev;
	logic sticky_q, trunc_q;
	logic [15:0] ver_q, ciph_q, ng_q;
	logic [7:0] comp_q, alvl_q, adesc_q;
	logic [5:0] sid_q;
	logic [10:0] cnt_q;
	logic [23:0] first_q, chain_q;
	logic [CAP_LW-1:0] pos_q, walk_q;
	logic [CAP_AW-1:0] rd_addr_q;
	logic [1:0] rd_left_q;
	logic [23:0] acc_q;
	logic out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic [15:0] len16, walk16;
	logic hl_short, sid_bad, cert_short, chain_cut, loop_go, cert_cut, emit_ok;
	logic [24:0] cert_sum;

	assign len16 = 16'(job_q.msg_len);
	assign walk16 = 16'(walk_q);
	assign hl_short = len16 < 16'(HELLO_MIN);
	assign sid_bad = (acc_q[7:0] > 8'(SID_MAX)) ||
		((16'(acc_q[7:0]) + 16'(HELLO_MIN)) > len16);
	assign cert_short = len16 < 16'(CERT_HDR);
	assign chain_cut = acc_q > (24'(job_q.msg_len) - 24'(CERT_HDR));
	assign loop_go = ((16'(pos_q) + 16'(CERT_HDR)) <= len16) &&
		((24'(pos_q) - 24'(CERT_HDR)) < chain_q);
	assign cert_sum = 25'(pos_q) + 25'(CERT_HDR) + 25'(acc_q);
	assign cert_cut = cert_sum > 25'(job_q.msg_len);
	assign emit_ok = !out_valid_q || m_tready;

	// record close events: pending events and the record bit, plus alert, ccs and unknown types
	always_comb begin
		fin_ev = pend_q;
		fin_ev[EV_RECORD] = 1'b1;
		if (job_q.rec_kind == REC_ALERT) begin
			if (job_q.rec_ge2 && job_q.alert0 == ALERT_FATAL) begin
				fin_ev[EV_ERROR] = 1'b1;
			end
			fin_ev[EV_ALERT] = 1'b1;
		end else if (job_q.rec_kind == REC_CCS) begin
			fin_ev[EV_CCS] = 1'b1;
		end else if (job_q.rec_kind != REC_HS && job_q.rec_kind != REC_APP) begin
			fin_ev[EV_ERROR] = 1'b1;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			B_IDLE: if (!q_empty) state_n = B_START;
			B_START: begin
				if (job_q.restart) state_n = B_IDLE;
				else if (job_q.err_only || job_q.oversize) state_n = B_EMIT;
				else if (job_q.msg) state_n = B_DISP;
				else if (job_q.rec_end) state_n = B_FIN;
				else state_n = B_IDLE;
			end
			B_DISP: begin
				case (job_q.msg_kind)
					HS_HELLO: state_n = hl_short ? B_AFTER : B_RD;
					HS_CERT: state_n = cert_short ? B_AFTER : B_RD;
					HS_KEYX: state_n = (len16 >= 16'(KEYX_MIN)) ? B_RD : B_AFTER;
					default: state_n = B_AFTER;
				endcase
			end
			B_RD: state_n = B_RDW;
			B_RDW: state_n = (rd_left_q == 2'd1) ? ret_q : B_RD;
			B_H_VER: state_n = B_RD;
			B_H_SID: state_n = sid_bad ? B_AFTER : B_RD;
			B_H_CIPH: state_n = B_RD;
			B_H_COMP: state_n = B_AFTER;
			B_C_CHAIN: state_n = chain_cut ? B_AFTER : B_C_LOOP;
			B_C_LOOP: state_n = loop_go ? B_RD : B_C_END;
			B_C_LEN: state_n = cert_cut ? B_C_END : B_C_LOOP;
			B_C_END: state_n = B_AFTER;
			B_K_0: state_n = (acc_q[7:0] == CURVE_NAMED) ? B_RD : B_AFTER;
			B_K_NG: state_n = B_AFTER;
			B_AFTER: state_n = job_q.rec_end ? B_FIN : B_IDLE;
			B_FIN: state_n = B_EMIT;
			B_EMIT: if (emit_ok) state_n = B_IDLE;
			default: state_n = B_IDLE;
		endcase
	end

	always_comb begin
		pop = (state_q == B_IDLE) && !q_empty;
		stat.idle = (state_q == B_IDLE);
		stat.sticky = sticky_q;
		stat.pend_err = pend_q[EV_ERROR];
		cap_raddr = rd_addr_q;
		m_tvalid = out_valid_q;
		m_tdata = out_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ret_q <= B_IDLE;
			job_q <= '0;
			pend_q <= '0;
			ev_q <= '0;
			sticky_q <= 1'b0;
			trunc_q <= 1'b0;
			ver_q <= '0;
			ciph_q <= '0;
			ng_q <= '0;
			comp_q <= '0;
			alvl_q <= '0;
			adesc_q <= '0;
			sid_q <= '0;
			cnt_q <= '0;
			first_q <= '0;
			chain_q <= '0;
			pos_q <= '0;
			walk_q <= '0;
			rd_addr_q <= '0;
			rd_left_q <= '0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			state_q <= state_n;
			case (state_q)
				B_IDLE: if (!q_empty) job_q <= head;
				B_START: begin
					if (job_q.restart) begin
						pend_q <= '0;
						sticky_q <= 1'b0;
						trunc_q <= 1'b0;
						ver_q <= '0;
						ciph_q <= '0;
						ng_q <= '0;
						comp_q <= '0;
						alvl_q <= '0;
						adesc_q <= '0;
						sid_q <= '0;
						cnt_q <= '0;
						first_q <= '0;
						chain_q <= '0;
					end else if (job_q.err_only) begin
						ev_q <= 9'(1) << EV_ERROR;
					end else begin
						if (job_q.pend_clear) pend_q <= '0;
						if (job_q.oversize) begin
							sticky_q <= 1'b1;
							ev_q <= 9'(1) << EV_ERROR;
						end
						if (job_q.trunc_clear) trunc_q <= 1'b0;
						if (job_q.trunc_set) trunc_q <= 1'b1;
					end
				end
				B_DISP: begin
					case (job_q.msg_kind)
						HS_HELLO: begin
							if (hl_short) begin
								pend_q[EV_ERROR] <= 1'b1;
							end else begin
								rd_addr_q <= '0;
								rd_left_q <= 2'd2;
								acc_q <= '0;
								ret_q <= B_H_VER;
							end
						end
						HS_CERT: begin
							if (cert_short) begin
								pend_q[EV_ERROR] <= 1'b1;
							end else begin
								rd_addr_q <= '0;
								rd_left_q <= 2'd3;
								acc_q <= '0;
								ret_q <= B_C_CHAIN;
							end
						end
						HS_KEYX: begin
							ng_q <= '0;
							if (len16 >= 16'(KEYX_MIN)) begin
								rd_addr_q <= '0;
								rd_left_q <= 2'd1;
								acc_q <= '0;
								ret_q <= B_K_0;
							end else begin
								pend_q[EV_KEYX] <= 1'b1;
							end
						end
						HS_CREQ: pend_q[EV_CREQ] <= 1'b1;
						HS_DONE: pend_q[EV_DONE] <= 1'b1;
						default: ;
					endcase
				end
				B_RDW: begin
					acc_q <= {acc_q[15:0], cap_rdata};
					rd_addr_q <= rd_addr_q + 1'b1;
					rd_left_q <= rd_left_q - 2'd1;
				end
				B_H_VER: begin
					ver_q <= acc_q[15:0];
					rd_addr_q <= CAP_AW'(SID_OFS);
					rd_left_q <= 2'd1;
					acc_q <= '0;
					ret_q <= B_H_SID;
				end
				B_H_SID: begin
					if (sid_bad) begin
						pend_q[EV_ERROR] <= 1'b1;
					end else begin
						sid_q <= acc_q[5:0];
						rd_addr_q <= CAP_AW'(SID_OFS + 1) + CAP_AW'(acc_q[7:0]);
						rd_left_q <= 2'd2;
						acc_q <= '0;
						ret_q <= B_H_CIPH;
					end
				end
				B_H_CIPH: begin
					ciph_q <= acc_q[15:0];
					rd_addr_q <= CAP_AW'(SID_OFS + 3) + CAP_AW'(sid_q);
					rd_left_q <= 2'd1;
					acc_q <= '0;
					ret_q <= B_H_COMP;
				end
				B_H_COMP: begin
					comp_q <= acc_q[7:0];
					pend_q[EV_HELLO] <= 1'b1;
				end
				B_C_CHAIN: begin
					chain_q <= acc_q;
					if (chain_cut) begin
						trunc_q <= 1'b1;
						pend_q[EV_CERT] <= 1'b1;
					end else begin
						pos_q <= CAP_LW'(CERT_HDR);
						walk_q <= '0;
					end
				end
				B_C_LOOP: begin
					if (loop_go) begin
						rd_addr_q <= pos_q[CAP_AW-1:0];
						rd_left_q <= 2'd3;
						acc_q <= '0;
						ret_q <= B_C_LEN;
					end
				end
				B_C_LEN: begin
					if (walk_q == '0) first_q <= acc_q;
					if (cert_cut) begin
						trunc_q <= 1'b1;
					end else begin
						pos_q <= cert_sum[CAP_LW-1:0];
						walk_q <= walk_q + 1'b1;
					end
				end
				B_C_END: begin
					cnt_q <= (walk16 > 16'(CNT_MAX)) ? 11'(CNT_MAX) : walk16[10:0];
					pend_q[EV_CERT] <= 1'b1;
				end
				B_K_0: begin
					if (acc_q[7:0] == CURVE_NAMED) begin
						rd_addr_q <= CAP_AW'(1);
						rd_left_q <= 2'd2;
						acc_q <= '0;
						ret_q <= B_K_NG;
					end else begin
						pend_q[EV_KEYX] <= 1'b1;
					end
				end
				B_K_NG: begin
					ng_q <= acc_q[15:0];
					pend_q[EV_KEYX] <= 1'b1;
				end
				B_FIN: begin
					ev_q <= fin_ev;
					if (job_q.rec_kind == REC_ALERT && job_q.rec_ge2) begin
						alvl_q <= job_q.alert0;
						adesc_q <= job_q.alert1;
					end
					if (fin_ev[EV_ERROR]) sticky_q <= 1'b1;
					pend_q <= '0;
				end
				default: ;
			endcase

			// result register
			if (state_q == B_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
				out_data_q <= {5'd0, trunc_q, adesc_q, alvl_q, ng_q, chain_q, first_q,
					cnt_q, sid_q, comp_q, ciph_q, ver_q, ev_q};
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/tls_record_handshake_parser_top.sv =====
// tls record and handshake parser, server-to-client direction. one stream byte per
// transaction on the s_ side (s_tuser = 1 restarts the parser and clears its state, the
// record limit excepted). records are split on their 5-byte header and handshake
// messages are rebuilt from type-22 payloads; the first CAPTURE_DEPTH body bytes of a
// message are kept in a capture ram (one write port, one read port) and parsed once
// the message ends. one result transaction leaves per finished record, per oversize
// header, and per byte after a sticky error. a plain payload byte leaves s_tready
// high. a byte that closes a record header or a message header, that draws an error
// result or that closes a record holds off the next byte until the back end has
// handled its job, and longer while the result register waits on m_tready. at a
// message end the parse reads the capture ram one byte at a time through a read state
// and a wait state. the capture ram needs no clearing after reset. the user must write
// record_limit on the cfg channel only while idle; the block does not enforce it.
module tls_record_handshake_parser_top (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,    // data_byte
	input logic [0:0] s_tuser,    // cmd
	output logic m_tvalid,
	input logic m_tready,
	// events, server_version, cipher, compression, session_id_length,
	// cert count, first_cert_length, chain bytes, named_group,
	// alert severity, alert code, truncated flag, zero fill
	output logic [trhp_pkg::OUT_W-1:0] m_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [15:0] cfg_data   // record_limit
);
	import trhp_pkg::*;

	logic [15:0] limit_q;
	bstat_t stat;
	job_t push_job, head;
	logic push, pop, q_empty;
	logic cap_we;
	logic [CAP_AW-1:0] cap_waddr, cap_raddr;
	logic [7:0] cap_wdata, cap_rdata;

	// register write always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 16'd18432;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// front: header tracking and capture writes
	trhp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.record_limit(limit_q),
		.stat(stat),
		.q_empty(q_empty),
		.push(push),
		.job(push_job),
		.cap_we(cap_we),
		.cap_waddr(cap_waddr),
		.cap_wdata(cap_wdata)
	);

	// job queue between the two halves
	trhp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head(head),
		.empty(q_empty)
	);

	trhp_ram #(
		.WIDTH(8),
		.DEPTH(CAPTURE_DEPTH)
	) u_cap (
		.clk(clk),
		.we(cap_we),
		.waddr(cap_waddr),
		.wdata(cap_wdata),
		.raddr(cap_raddr),
		.rdata(cap_rdata)
	);

	// back: message parse, record close and result register
	trhp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_empty(q_empty),
		.pop(pop),
		.stat(stat),
		.cap_raddr(cap_raddr),
		.cap_rdata(cap_rdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// capture writes never overlap a parse
	a_cap_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cap_we |-> stat.idle)
		else $error("capture write while back end busy");

	// the queue only takes a job when it is empty
	a_push_empty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> q_empty)
		else $error("job pushed into a busy queue");

	// a new sticky error is reported before any further byte is taken
	a_sticky_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stat.sticky) |-> !s_tready)
		else $error("byte taken while sticky error result pending");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// tls record and handshake parser testbench: a short directed table, then phases
// of random record streams under several record limits, all checked against a
// bit-accurate parser predictor run on every accepted input transaction
module tb_top;
	import trhp_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	// one result transaction, packed from the highest field down
	typedef struct packed {
		logic [4:0] pad;
		logic trunc;
		logic [7:0] alert_desc;
		logic [7:0] alert_lvl;
		logic [15:0] group;
		logic [23:0] chain_bytes;
		logic [23:0] first_len;
		logic [10:0] cert_cnt;
		logic [5:0] sid_len;
		logic [7:0] comp;
		logic [15:0] cipher;
		logic [15:0] version;
		logic [8:0] events;
	} parse_result_t;

	// directed stimulus row: check_ev marks rows whose events are known by inspection
	typedef struct {
		logic cmd;
		logic [7:0] data;
		logic check_ev;
		logic [8:0] ev;
	} dir_row_t;

	localparam logic [8:0] M_RECORD = 9'(1) << EV_RECORD;
	localparam logic [8:0] M_HELLO = 9'(1) << EV_HELLO;
	localparam logic [8:0] M_CERT = 9'(1) << EV_CERT;
	localparam logic [8:0] M_KEYX = 9'(1) << EV_KEYX;
	localparam logic [8:0] M_CREQ = 9'(1) << EV_CREQ;
	localparam logic [8:0] M_DONE = 9'(1) << EV_DONE;
	localparam logic [8:0] M_ALERT = 9'(1) << EV_ALERT;
	localparam logic [8:0] M_CCS = 9'(1) << EV_CCS;
	localparam logic [8:0] M_ERROR = 9'(1) << EV_ERROR;
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	tls_record_handshake_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop in case the handshakes hang
	initial begin
		#4000000;
		$display("** tls_record_handshake_parser_top: FAILED **");
		$finish;
	end

	// ---------------------------------------------------------------- predictor state
	int unsigned lim;
	int unsigned rec_hdr_cnt, rec_kind, rec_len, rec_rcvd;
	logic [7:0] alert_buf[2];
	int unsigned hs_hdr_cnt, hs_kind, hs_len, hs_rcvd;
	logic [7:0] cap_mem[CAPTURE_DEPTH];
	logic trunc_flag;
	logic [8:0] pend_ev;
	logic sticky;
	logic [15:0] p_version, p_cipher, p_group;
	logic [7:0] p_comp, p_alvl, p_adesc;
	logic [5:0] p_sid;
	logic [10:0] p_cnt;
	logic [23:0] p_first, p_chain;

	parse_result_t predicted_results[$];
	int fail_cnt = 0;
	int mismatch_cnt = 0;
	int items_sent = 0;
	bit no_idle = 0;

	function automatic void clear_parser();
		rec_hdr_cnt = 0; rec_kind = 0; rec_len = 0; rec_rcvd = 0;
		alert_buf[0] = 0; alert_buf[1] = 0;
		hs_hdr_cnt = 0; hs_kind = 0; hs_len = 0; hs_rcvd = 0;
		trunc_flag = 0; pend_ev = 0; sticky = 0;
		p_version = 0; p_cipher = 0; p_group = 0; p_comp = 0;
		p_alvl = 0; p_adesc = 0; p_sid = 0; p_cnt = 0; p_first = 0; p_chain = 0;
	endfunction

	function automatic int unsigned cap_byte(int unsigned i);
		return (i < CAPTURE_DEPTH) ? int'(cap_mem[i]) : 0;
	endfunction

	function automatic int unsigned cap_be16(int unsigned i);
		return (cap_byte(i) << 8) | cap_byte(i + 1);
	endfunction

	function automatic int unsigned cap_be24(int unsigned i);
		return (cap_byte(i) << 16) | (cap_byte(i + 1) << 8) | cap_byte(i + 2);
	endfunction

	function automatic logic [8:0] parse_hello(int unsigned len);
		int unsigned sid;
		if (len < HELLO_MIN)
			return M_ERROR;
		p_version = 16'(cap_be16(0));
		sid = cap_byte(SID_OFS);
		if (sid > SID_MAX || 35 + sid + 3 > len)
			return M_ERROR;
		p_sid = 6'(sid);
		p_cipher = 16'(cap_be16(35 + sid));
		p_comp = 8'(cap_byte(37 + sid));
		return M_HELLO;
	endfunction

	// walks the certificate list inside the captured bytes
	function automatic logic [8:0] parse_cert(int unsigned len);
		int unsigned pos, chain, cnt, cl;
		pos = CERT_HDR;
		cnt = 0;
		if (len < CERT_HDR)
			return M_ERROR;
		chain = cap_be24(0);
		p_chain = 24'(chain);
		if (chain > len - 3) begin
			trunc_flag = 1;
			return M_CERT;
		end
		while (pos + 3 <= len && pos - 3 < chain) begin
			cl = cap_be24(pos);
			pos += 3;
			if (cnt == 0)
				p_first = 24'(cl);
			if (pos + cl > len) begin
				trunc_flag = 1;
				break;
			end
			pos += cl;
			cnt++;
		end
		if (cnt > CNT_MAX)
			cnt = CNT_MAX;
		p_cnt = 11'(cnt);
		return M_CERT;
	endfunction

	function automatic logic [8:0] parse_message(int unsigned kind, int unsigned len);
		case (kind)
			HS_HELLO: return parse_hello(len);
			HS_CERT: return parse_cert(len);
			HS_KEYX: begin
				p_group = '0;
				if (len >= KEYX_MIN && cap_byte(0) == CURVE_NAMED)
					p_group = 16'(cap_be16(1));
				return M_KEYX;
			end
			HS_CREQ: return M_CREQ;
			HS_DONE: return M_DONE;
			default: return '0;
		endcase
	endfunction

	function automatic void handshake_in(logic [7:0] b);
		int unsigned clen;
		if (hs_hdr_cnt < 4) begin
			if (hs_hdr_cnt == 0) begin
				hs_kind = 32'(b);
				hs_len = 0;
			end else begin
				hs_len = ((hs_len << 8) | 32'(b)) & 24'hFFFFFF;
			end
			hs_hdr_cnt++;
			if (hs_hdr_cnt == 4) begin
				hs_rcvd = 0;
				trunc_flag = 0;
				if (hs_len == 0) begin
					pend_ev |= parse_message(hs_kind, 0);
					hs_hdr_cnt = 0;
				end
			end
			return;
		end
		if (hs_rcvd < CAPTURE_DEPTH)
			cap_mem[hs_rcvd] = b;
		if (hs_rcvd + 1 > CAPTURE_DEPTH)
			trunc_flag = 1;
		hs_rcvd++;
		if (hs_rcvd == hs_len) begin
			clen = (hs_len < CAPTURE_DEPTH) ? hs_len : CAPTURE_DEPTH;
			pend_ev |= parse_message(hs_kind, clen);
			hs_hdr_cnt = 0; hs_kind = 0; hs_len = 0; hs_rcvd = 0;
		end
	endfunction

	function automatic parse_result_t make_result(logic [8:0] ev);
		parse_result_t r;
		r = '0;
		r.events = ev;
		r.version = p_version;
		r.cipher = p_cipher;
		r.comp = p_comp;
		r.sid_len = p_sid;
		r.cert_cnt = p_cnt;
		r.first_len = p_first;
		r.chain_bytes = p_chain;
		r.group = p_group;
		r.alert_lvl = p_alvl;
		r.alert_desc = p_adesc;
		r.trunc = trunc_flag;
		return r;
	endfunction

	function automatic logic [8:0] close_record();
		logic [8:0] ev;
		ev = pend_ev | M_RECORD;
		if (rec_kind == REC_ALERT) begin
			if (rec_len >= 2) begin
				p_alvl = alert_buf[0];
				p_adesc = alert_buf[1];
				if (alert_buf[0] == ALERT_FATAL)
					ev |= M_ERROR;
			end
			ev |= M_ALERT;
		end else if (rec_kind == REC_CCS) begin
			ev |= M_CCS;
		end else if (rec_kind != REC_HS && rec_kind != REC_APP) begin
			ev |= M_ERROR;
		end
		if (ev & M_ERROR)
			sticky = 1;
		rec_hdr_cnt = 0; rec_rcvd = 0; rec_len = 0; pend_ev = 0;
		return ev;
	endfunction

	// one accepted input transaction; returns 1 when a result is due
	function automatic bit parser_predict(logic cmd, logic [7:0] b, output parse_result_t r);
		int unsigned idx;
		r = '0;
		if (cmd == CMD_RESTART) begin
			clear_parser();
			return 0;
		end
		if (sticky) begin
			r = make_result(M_ERROR);
			return 1;
		end
		if (rec_hdr_cnt <= REC_HDR_LAST) begin
			idx = rec_hdr_cnt++;
			if (idx == 0)
				rec_kind = 32'(b);
			else if (idx == 3)
				rec_len = int'(b) << 8;
			else if (idx == 4)
				rec_len |= 32'(b);
			if (rec_hdr_cnt <= REC_HDR_LAST)
				return 0;
			rec_rcvd = 0;
			pend_ev = 0;
			if (rec_len > lim) begin
				sticky = 1;
				r = make_result(M_ERROR);
				return 1;
			end
			if (rec_len == 0) begin
				r = make_result(close_record());
				return 1;
			end
			return 0;
		end
		if (rec_kind == REC_HS && !(pend_ev & M_ERROR))
			handshake_in(b);
		else if (rec_kind == REC_ALERT && rec_rcvd < 2)
			alert_buf[rec_rcvd] = b;
		rec_rcvd++;
		if (rec_rcvd >= rec_len) begin
			r = make_result(close_record());
			return 1;
		end
		return 0;
	endfunction

	// ---------------------------------------------------------------- drivers
	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 4);
	endfunction

	// drives one stream transaction and predicts at its acceptance
	task automatic send_byte(logic cmd, logic [7:0] b, output parse_result_t r,
			output bit has_res);
		int gap;
		bit rdy;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= cmd;
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		items_sent++;
		has_res = parser_predict(cmd, b, r);
		if (has_res)
			predicted_results.push_back(r);
	endtask

	task automatic put(logic cmd, logic [7:0] b);
		parse_result_t r;
		bit h;
		send_byte(cmd, b, r, h);
	endtask

	task automatic send_record(logic [7:0] kind, byte_q_t pl);
		put(CMD_BYTE, kind);
		put(CMD_BYTE, 8'd3);
		put(CMD_BYTE, 8'($urandom_range(0, 4)));
		put(CMD_BYTE, 8'(pl.size() >> 8));
		put(CMD_BYTE, 8'(pl.size()));
		foreach (pl[i])
			put(CMD_BYTE, pl[i]);
	endtask

	// pause the sender until every predicted result has arrived, then let it settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_limit(logic [15:0] v);
		bit rdy;
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 1'b0;
		lim = 32'(v);
	endtask

	// ---------------------------------------------------------------- message builders
	function automatic void push_rand(ref byte_q_t q, input int n);
		repeat (n) q.push_back(8'($urandom));
	endfunction

	function automatic void add_message(ref byte_q_t q, input logic [7:0] kind,
			input byte_q_t body);
		q.push_back(kind);
		q.push_back(8'(body.size() >> 16));
		q.push_back(8'(body.size() >> 8));
		q.push_back(8'(body.size()));
		foreach (body[i])
			q.push_back(body[i]);
	endfunction

	function automatic byte_q_t build_hello();
		byte_q_t b;
		int sid;
		b.push_back(8'd3);
		b.push_back(8'($urandom_range(0, 3) == 0 ? $urandom : 3));
		push_rand(b, 32);
		sid = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 32);
		b.push_back(8'(sid));
		push_rand(b, (sid > 40) ? 40 : sid);
		push_rand(b, 3 + $urandom_range(0, 6));
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 20)) if (b.size() > 0) void'(b.pop_back());
		return b;
	endfunction

	function automatic byte_q_t build_cert();
		byte_q_t b, certs;
		int n, cl, chain;
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++) begin
			cl = $urandom_range(0, 20);
			certs.push_back(8'(cl >> 16));
			certs.push_back(8'(cl >> 8));
			certs.push_back(8'(cl));
			push_rand(certs, cl);
		end
		chain = certs.size();
		case ($urandom_range(0, 7))
			0: chain += $urandom_range(1, 8);
			1: chain = $urandom;
			default: ;
		endcase
		b.push_back(8'(chain >> 16));
		b.push_back(8'(chain >> 8));
		b.push_back(8'(chain));
		foreach (certs[i])
			b.push_back(certs[i]);
		if ($urandom_range(0, 6) == 0)
			repeat ($urandom_range(1, 10)) if (b.size() > 0) void'(b.pop_back());
		return b;
	endfunction

	function automatic byte_q_t build_keyx();
		byte_q_t b;
		b.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : CURVE_NAMED);
		push_rand(b, 2 + $urandom_range(0, 10));
		if ($urandom_range(0, 5) == 0)
			while (b.size() > $urandom_range(0, 3)) void'(b.pop_back());
		return b;
	endfunction

	// a flight of handshake messages spread over records of random size
	task automatic send_flight(int max_rec);
		byte_q_t hs, body, pl;
		logic [7:0] kind;
		int n;
		repeat ($urandom_range(1, 3)) begin
			body.delete();
			case ($urandom_range(0, 6))
				0: begin kind = HS_HELLO; body = build_hello(); end
				1: begin kind = HS_CERT; body = build_cert(); end
				2: begin kind = HS_KEYX; body = build_keyx(); end
				3: begin kind = HS_CREQ; push_rand(body, $urandom_range(0, 4)); end
				4: begin kind = HS_DONE; push_rand(body, $urandom_range(0, 2)); end
				5: begin kind = 8'($urandom); push_rand(body, $urandom_range(0, 6)); end
				default: begin kind = HS_HELLO; body = build_hello(); end
			endcase
			add_message(hs, kind, body);
		end
		while (hs.size() > 0) begin
			pl.delete();
			n = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, max_rec);
			repeat (n) if (hs.size() > 0) pl.push_back(hs.pop_front());
			send_record(REC_HS, pl);
		end
	endtask

	task automatic random_phase(int target);
		byte_q_t pl;
		int k, stop;
		stop = items_sent + target;
		while (items_sent < stop) begin
			pl.delete();
			k = $urandom_range(0, 99);
			if (k < 55) begin
				send_flight(48);
			end else if (k < 65) begin
				pl.push_back(8'($urandom_range(0, 1) ? $urandom_range(1, 2) : $urandom));
				push_rand(pl, 1);
				repeat ($urandom_range(0, 3)) if (pl.size() > 0) void'(pl.pop_back());
				push_rand(pl, $urandom_range(0, 1));
				send_record(REC_ALERT, pl);
			end else if (k < 72) begin
				push_rand(pl, 1);
				send_record(REC_CCS, pl);
			end else if (k < 80) begin
				push_rand(pl, $urandom_range(0, 30));
				send_record(REC_APP, pl);
			end else if (k < 84) begin
				push_rand(pl, $urandom_range(0, 10));
				send_record(8'($urandom), pl);
			end else if (k < 88) begin
				if (lim < 200) begin
					push_rand(pl, lim + 1);
					send_record(REC_APP, pl);
				end else begin
					put(CMD_BYTE, REC_HS);
					put(CMD_BYTE, 8'd3);
					put(CMD_BYTE, 8'd3);
					put(CMD_BYTE, 8'((lim + 1) >> 8));
					put(CMD_BYTE, 8'(lim + 1));
				end
			end else if (k < 94) begin
				repeat ($urandom_range(1, 8)) put(CMD_BYTE, 8'($urandom));
				put(CMD_RESTART, 8'($urandom));
			end else begin
				put(CMD_RESTART, 8'($urandom));
			end
			// leave the sticky error state after a few error results
			if (sticky) begin
				repeat ($urandom_range(0, 3)) put(CMD_BYTE, 8'($urandom));
				put(CMD_RESTART, 8'($urandom));
			end
		end
		// close any record left open by a restart-free path
		if (rec_hdr_cnt != 0 || rec_len != 0)
			put(CMD_RESTART, 8'($urandom));
	endtask

	// ---------------------------------------------------------------- result checking
	task automatic check_field(string nm, longint unsigned e, longint unsigned a);
		if (e != a) begin
			fail_cnt++;
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("mismatch %s: expected %0h actual %0h", nm, e, a);
		end
	endtask

	task automatic check_result(parse_result_t a);
		parse_result_t e;
		if (predicted_results.size() == 0) begin
			fail_cnt++;
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("unexpected result transaction, events %0h", a.events);
			return;
		end
		e = predicted_results.pop_front();
		check_field("events", e.events, a.events);
		check_field("server_version", e.version, a.version);
		check_field("cipher", e.cipher, a.cipher);
		check_field("compression", e.comp, a.comp);
		check_field("session_id_length", e.sid_len, a.sid_len);
		check_field("cert count", e.cert_cnt, a.cert_cnt);
		check_field("first_cert_length", e.first_len, a.first_len);
		check_field("chain bytes", e.chain_bytes, a.chain_bytes);
		check_field("named_group", e.group, a.group);
		check_field("alert severity", e.alert_lvl, a.alert_lvl);
		check_field("alert code", e.alert_desc, a.alert_desc);
		check_field("truncated flag", e.trunc, a.trunc);
		check_field("zero fill", e.pad, a.pad);
	endtask

	// result side: random stalls, sampled at the falling edge ahead of the transaction
	initial begin
		int stall;
		bit v;
		parse_result_t d;
		@(posedge arst_n);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do begin
				@(negedge clk);
				v = m_tvalid;
				d = m_tdata;
				@(posedge clk);
			end while (!v);
			check_result(d);
		end
	end

	// ---------------------------------------------------------------- main sequence
	initial begin
		dir_row_t rows[$];
		parse_result_t r;
		bit h;

		lim = 18432;
		clear_parser();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty app record, finished at its last header byte
		rows.push_back('{CMD_BYTE, REC_APP, 0, 0});
		rows.push_back('{CMD_BYTE, 8'd3, 0, 0});
		rows.push_back('{CMD_BYTE, 8'd3, 0, 0});
		rows.push_back('{CMD_BYTE, 8'd0, 0, 0});
		rows.push_back('{CMD_BYTE, 8'd0, 1, M_RECORD});
		// one-byte change cipher spec
		rows.push_back('{CMD_BYTE, REC_CCS, 0, 0});
		rows.push_back('{CMD_BYTE, 8'd3, 0, 0});
		rows.push_back('{CMD_BYTE, 8'd3, 0, 0});
		rows.push_back('{CMD_BYTE, 8'd0, 0, 0});
		rows.push_back('{CMD_BYTE, 8'd1, 0, 0});
		rows.push_back('{CMD_BYTE, 8'hFF, 1, M_RECORD | M_CCS});
		// fatal alert, error turns sticky
		rows.push_back('{CMD_BYTE, REC_ALERT, 0, 0});
		rows.push_back('{CMD_BYTE, 8'd3, 0, 0});
		rows.push_back('{CMD_BYTE, 8'd3, 0, 0});
		rows.push_back('{CMD_BYTE, 8'd0, 0, 0});
		rows.push_back('{CMD_BYTE, 8'd2, 0, 0});
		rows.push_back('{CMD_BYTE, ALERT_FATAL, 0, 0});
		rows.push_back('{CMD_BYTE, 8'd40, 1, M_RECORD | M_ALERT | M_ERROR});
		rows.push_back('{CMD_BYTE, 8'h00, 1, M_ERROR});
		rows.push_back('{CMD_RESTART, 8'hFF, 0, 0});
		// oversize record at the default limit
		rows.push_back('{CMD_BYTE, REC_HS, 0, 0});
		rows.push_back('{CMD_BYTE, 8'd3, 0, 0});
		rows.push_back('{CMD_BYTE, 8'd3, 0, 0});
		rows.push_back('{CMD_BYTE, 8'hFF, 0, 0});
		rows.push_back('{CMD_BYTE, 8'hFF, 1, M_ERROR});
		foreach (rows[i]) begin
			send_byte(rows[i].cmd, rows[i].data, r, h);
			if (rows[i].check_ev && (!h || r.events != rows[i].ev)) begin
				fail_cnt++;
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("directed row %0d: expected events %0h, actual %0h",
							i, rows[i].ev, r.events);
			end
		end
		put(CMD_RESTART, 8'h00);
		drain();

		random_phase(350);
		drain();

		write_limit(16'hFFFF);
		no_idle = 1;
		random_phase(250);
		drain();

		write_limit(16'h0000);
		no_idle = 0;
		random_phase(60);
		drain();

		write_limit(16'd30);
		random_phase(200);
		drain();

		write_limit(16'($urandom_range(16, 300)));
		random_phase(250);
		drain();

		if (fail_cnt == 0 && predicted_results.size() == 0) begin
			$display("** tls_record_handshake_parser_top: PASSED **");
		end else begin
			$display("** tls_record_handshake_parser_top: FAILED **");
		end
		$finish;
	end

endmodule

// ===== tls_record_handshake_parser_top.f =====
design/trhp_pkg.sv
design/trhp_ram.sv
design/trhp_queue.sv
design/trhp_front.sv
design/trhp_back.sv
design/tls_record_handshake_parser_top.sv
sim/tb_top.sv
